// ===== design/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr must never hold at a clock edge outside reset
`define AST_NEVER(lbl, expr, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
else $error(msg);

// ante implies cons at the same edge
`define AST_IMPLY(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
else $error(msg);

`endif

// ===== design/plc_pkg.sv =====
`timescale 1ns / 1ps

package plc_pkg;

	localparam logic [2:0] OP_INS_FRONT = 3'd0;
	localparam logic [2:0] OP_INS_POS   = 3'd1;
	localparam logic [2:0] OP_INS_END   = 3'd2;
	localparam logic [2:0] OP_DEL_FRONT = 3'd3;
	localparam logic [2:0] OP_DEL_POS   = 3'd4;
	localparam logic [2:0] OP_DEL_END   = 3'd5;
	localparam logic [2:0] OP_DUMP      = 3'd6;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_INVALID = 3'd1;
	localparam logic [2:0] ST_OOB     = 3'd2;
	localparam logic [2:0] ST_EMPTY   = 3'd3;
	localparam logic [2:0] ST_FULL    = 3'd4;

	typedef struct packed {
		logic [2:0]         opcode;
		logic signed [31:0] value;
		logic [7:0]         position;
	} in_word_t;

	typedef struct packed {
		logic [2:0]         status;
		logic signed [31:0] item;
		logic               last;
	} out_word_t;

	// result word offered by the controller to the output register
	typedef struct packed {
		logic      valid;
		out_word_t word;
	} push_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SHIFT,
		S_PUT,
		S_DUMP_RD,
		S_DUMP_WAIT,
		S_RESP
	} fsm_t;

	typedef enum logic [1:0] {
		K_RESP,
		K_INS,
		K_DEL,
		K_DUMP
	} kind_t;

endpackage

// ===== design/plc_mem.sv =====
`timescale 1ns / 1ps

module plc_mem #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [31:0]       wdata,
	input  logic              re,
	input  logic [AW-1:0]     raddr,
	output logic [31:0]       rdata
);

	logic [31:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read, held while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== design/plc_ctrl.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module plc_ctrl #(
	parameter int CAPACITY = 16,
	parameter int AW       = 4,
	parameter int LW       = 5
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  plc_pkg::in_word_t req,
	output plc_pkg::push_t    push,
	input  logic              push_ok,
	output logic              mem_we,
	output logic [AW-1:0]     mem_waddr,
	output logic [31:0]       mem_wdata,
	output logic              mem_re,
	output logic [AW-1:0]     mem_raddr,
	input  logic [31:0]       mem_rdata
);

	localparam int CW = ((LW > 8) ? LW : 8) + 1;

	plc_pkg::fsm_t  state_q, state_d;
	logic [2:0]     op_q;
	logic [31:0]    val_q;
	logic [7:0]     pos_q;
	logic [LW-1:0]  len_q;
	logic [LW-1:0]  cnt_q;
	logic [AW-1:0]  src_q;
	logic [AW-1:0]  slot_q;
	logic           dir_q;
	logic [2:0]     status_q;
	logic           wpend_s1;
	logic [AW-1:0]  waddr_s1;

	plc_pkg::kind_t ex_kind;
	logic [2:0]     ex_st;
	logic [AW-1:0]  ex_slot;
	logic           full, empty;
	logic [CW-1:0]  posx, lenx;

	assign full  = (len_q == LW'(CAPACITY));
	assign empty = (len_q == '0);
	assign posx  = CW'(pos_q);
	assign lenx  = CW'(len_q);

	// decode of the latched request against the current length
	always_comb begin
		ex_kind = plc_pkg::K_RESP;
		ex_st   = plc_pkg::ST_OK;
		ex_slot = '0;
		unique case (op_q)
			plc_pkg::OP_INS_FRONT, plc_pkg::OP_INS_END: begin
				if (full) begin
					ex_st = plc_pkg::ST_FULL;
				end else begin
					ex_kind = plc_pkg::K_INS;
					ex_slot = (op_q == plc_pkg::OP_INS_FRONT) ? '0 : AW'(len_q);
				end
			end
			plc_pkg::OP_INS_POS: begin
				priority if (pos_q == 8'd0) begin
					ex_st = plc_pkg::ST_INVALID;
				end else if (full) begin
					ex_st = plc_pkg::ST_FULL;
				end else if (posx > lenx + CW'(1)) begin
					ex_st = plc_pkg::ST_OOB;
				end else begin
					ex_kind = plc_pkg::K_INS;
					ex_slot = AW'(pos_q - 8'd1);
				end
			end
			plc_pkg::OP_DEL_FRONT, plc_pkg::OP_DEL_END: begin
				if (empty) begin
					ex_st = plc_pkg::ST_EMPTY;
				end else begin
					ex_kind = plc_pkg::K_DEL;
					ex_slot = (op_q == plc_pkg::OP_DEL_FRONT) ? '0 : AW'(len_q - LW'(1));
				end
			end
			plc_pkg::OP_DEL_POS: begin
				priority if (empty) begin
					ex_st = plc_pkg::ST_EMPTY;
				end else if (pos_q == 8'd0) begin
					ex_st = plc_pkg::ST_INVALID;
				end else if (posx > lenx) begin
					ex_st = plc_pkg::ST_OOB;
				end else begin
					ex_kind = plc_pkg::K_DEL;
					ex_slot = AW'(pos_q - 8'd1);
				end
			end
			plc_pkg::OP_DUMP: begin
				if (empty) begin
					ex_st = plc_pkg::ST_EMPTY;
				end else begin
					ex_kind = plc_pkg::K_DUMP;
				end
			end
			default: begin
				ex_st = plc_pkg::ST_OK;
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			plc_pkg::S_IDLE: begin
				if (req_valid) state_d = plc_pkg::S_EXEC;
			end
			plc_pkg::S_EXEC: begin
				unique case (ex_kind)
					plc_pkg::K_INS, plc_pkg::K_DEL: state_d = plc_pkg::S_SHIFT;
					plc_pkg::K_DUMP:                state_d = plc_pkg::S_DUMP_RD;
					default:                        state_d = plc_pkg::S_RESP;
				endcase
			end
			plc_pkg::S_SHIFT: begin
				if (cnt_q == '0) state_d = dir_q ? plc_pkg::S_RESP : plc_pkg::S_PUT;
			end
			plc_pkg::S_PUT: begin
				state_d = plc_pkg::S_RESP;
			end
			plc_pkg::S_DUMP_RD: begin
				state_d = plc_pkg::S_DUMP_WAIT;
			end
			plc_pkg::S_DUMP_WAIT: begin
				if (push_ok) begin
					state_d = (cnt_q == LW'(1)) ? plc_pkg::S_IDLE : plc_pkg::S_DUMP_RD;
				end
			end
			plc_pkg::S_RESP: begin
				if (push_ok) state_d = plc_pkg::S_IDLE;
			end
			default: begin
				state_d = plc_pkg::S_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		req_stall  = (state_q != plc_pkg::S_IDLE);
		mem_re     = 1'b0;
		mem_raddr  = src_q;
		mem_we     = wpend_s1;
		mem_waddr  = waddr_s1;
		mem_wdata  = mem_rdata;
		push.valid = 1'b0;
		push.word  = '{status: status_q, item: 32'sd0, last: 1'b1};
		unique case (state_q)
			plc_pkg::S_SHIFT: begin
				mem_re = (cnt_q != '0);
			end
			plc_pkg::S_PUT: begin
				mem_we    = 1'b1;
				mem_waddr = slot_q;
				mem_wdata = val_q;
			end
			plc_pkg::S_DUMP_RD: begin
				mem_re = 1'b1;
			end
			plc_pkg::S_DUMP_WAIT: begin
				push.valid = 1'b1;
				push.word  = '{status: plc_pkg::ST_OK, item: mem_rdata,
				              last: (cnt_q == LW'(1))};
			end
			plc_pkg::S_RESP: begin
				push.valid = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= plc_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else if (state_q == plc_pkg::S_PUT) begin
			len_q <= len_q + LW'(1);
		end else if (state_q == plc_pkg::S_SHIFT && cnt_q == '0 && dir_q) begin
			len_q <= len_q - LW'(1);
		end
	end

	// move pipeline: read issued now, write back next cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wpend_s1 <= 1'b0;
		end else begin
			wpend_s1 <= (state_q == plc_pkg::S_SHIFT) && (cnt_q != '0);
		end
	end

	always_ff @(posedge clk) begin
		waddr_s1 <= dir_q ? (src_q - AW'(1)) : (src_q + AW'(1));
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			plc_pkg::S_IDLE: begin
				if (req_valid) begin
					op_q  <= req.opcode;
					val_q <= req.value;
					pos_q <= req.position;
				end
			end
			plc_pkg::S_EXEC: begin
				status_q <= ex_st;
				slot_q   <= ex_slot;
				unique case (ex_kind)
					plc_pkg::K_INS: begin
						cnt_q <= len_q - LW'(ex_slot);
						src_q <= AW'(len_q - LW'(1));
						dir_q <= 1'b0;
					end
					plc_pkg::K_DEL: begin
						cnt_q <= len_q - LW'(ex_slot) - LW'(1);
						src_q <= ex_slot + AW'(1);
						dir_q <= 1'b1;
					end
					plc_pkg::K_DUMP: begin
						cnt_q <= len_q;
						src_q <= '0;
					end
					default: begin
					end
				endcase
			end
			plc_pkg::S_SHIFT: begin
				if (cnt_q != '0) begin
					cnt_q <= cnt_q - LW'(1);
					src_q <= dir_q ? (src_q + AW'(1)) : (src_q - AW'(1));
				end
			end
			plc_pkg::S_DUMP_WAIT: begin
				if (push_ok) begin
					cnt_q <= cnt_q - LW'(1);
					src_q <= src_q + AW'(1);
				end
			end
			default: begin
			end
		endcase
	end

	`AST_NEVER(a_len_cap, len_q > LW'(CAPACITY), "length above capacity")
	`AST_NEVER(a_rw_clash, mem_we && mem_re && (mem_waddr == mem_raddr), "read and write same entry")
	`AST_NEVER(a_we_idle, mem_we && (state_q == plc_pkg::S_IDLE), "memory write while idle")
	`AST_IMPLY(a_len_step, len_q != $past(len_q), state_q == plc_pkg::S_RESP, "length moved off response")

endmodule

// ===== design/positional_list_store_top.sv =====
// Insert: decode, shift later entries up, write the value, send status. Delete: decode, shift
// later entries down, send status. Dump: each value is read through the entry memory's single
// registered read port, then out. One request at a time: req_stall is high until it is done.
// Reset: arst_n clears length and control; entry memory is not cleared.
`timescale 1ns / 1ps

module positional_list_store_top #(
	parameter int CAPACITY = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  plc_pkg::in_word_t  req,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output plc_pkg::out_word_t rsp
);

	// entry index and length widths
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int LW = $clog2(CAPACITY + 1);

	plc_pkg::push_t     push;
	logic               push_ok;
	logic               mem_we, mem_re;
	logic [AW-1:0]      mem_waddr, mem_raddr;
	logic [31:0]        mem_wdata, mem_rdata;
	logic               rsp_valid_q;
	plc_pkg::out_word_t rsp_q;

	// sequencer: decode, shift moves, dump walk
	plc_ctrl #(
		.CAPACITY (CAPACITY),
		.AW       (AW),
		.LW       (LW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.push      (push),
		.push_ok   (push_ok),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	// list entries, one read and one write per cycle
	plc_mem #(
		.DEPTH (CAPACITY),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// output register: takes a new word when empty or being drained
	assign push_ok = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (push_ok) begin
			rsp_valid_q <= push.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (push_ok && push.valid) begin
			rsp_q <= push.word;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
